@@ sv/deque_with_typed_extract_macros.svh @@
// ---------------------------------------------------------------------------
// deque_with_typed_extract assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_TYPED_EXTRACT_MACROS_SVH
`define DEQUE_WITH_TYPED_EXTRACT_MACROS_SVH

// condition holds at every edge out of reset
`define DQT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define DQT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dqt_pkg.sv @@
// ---------------------------------------------------------------------------
// dqt_pkg
// types and codes shared by the deque cell row and its controller
// ---------------------------------------------------------------------------
package dqt_pkg;

	// operation codes carried in s_tuser
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_BACK   = 3'd3;
	localparam logic [2:0] KIND_TAKE       = 3'd4;

	// result status codes carried in m_tuser
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam int TYPE_W = 8;

	// how the whole row moves: hold, shift up or shift down
	typedef enum logic [1:0] {
		SH_HOLD,
		SH_UP,
		SH_DOWN
	} shift_mode_t;

	typedef struct packed {
		shift_mode_t mode;
		logic        ld;
	} shift_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

@@ sv/deque_with_typed_extract.sv @@
// ---------------------------------------------------------------------------
// deque_with_typed_extract
// bounded double-ended message queue kept as a row of shifting cells,
// with take-first-by-type done by rotating the row past its head
// ---------------------------------------------------------------------------
//  channel  dir  tdata                                 tuser
//  s_*      in   msg_type, payload                     kind
//  m_*      out  out_type, out_payload, fill, totals   status
//
//  push back, push front, pop front and pop back may follow one another in
//  every cycle while the result register drains.
//  take by type rotates the row one entry per cycle through the head cell,
//  dropping the first match; no item is taken during the rotation.
//  s_tready is low while the result register holds an item that m_tready
//  has not taken. reset empties the queue and clears all totals.
// ---------------------------------------------------------------------------
`include "deque_with_typed_extract_macros.svh"

module deque_with_typed_extract #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // msg_type[7:0], payload[39:8]
	input  logic [2:0]   s_tuser,   // kind[2:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_type[7:0], out_payload[39:8], fill_count[44:40],
	// overflow_total[76:45], push_front_total[108:77],
	// push_back_total[140:109], pop_front_total[172:141],
	// pop_back_total[204:173], zero[207:205]
	output logic [207:0] m_tdata,
	output logic [1:0]   m_tuser    // status[1:0]
);

	localparam int ENTRY_W = dqt_pkg::TYPE_W + PAYLOAD_BITS;
	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

	dqt_pkg::state_t      state_q, state_d;
	dqt_pkg::shift_ctrl_t shift;
	logic [IDX_W-1:0]     ld_idx;
	logic [IDX_W-1:0]     rd_idx;
	logic [ENTRY_W-1:0]   ins;
	logic [ENTRY_W-1:0]   cell_data [QUEUE_DEPTH];
	logic [ENTRY_W-1:0]   cell_rd   [QUEUE_DEPTH];
	logic [ENTRY_W-1:0]   back_rd;
	logic [ENTRY_W-1:0]   head;
	logic [63:0]          pay_wide;
	logic [ENTRY_W-1:0]   new_entry;

	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [CNT_W-1:0]     steps_q, steps_d;
	logic                 found_q, found_d;
	logic [ENTRY_W-1:0]   fnd_q, fnd_d;
	logic [7:0]           stype_q, stype_d;
	logic [31:0]          ovf_q, ovf_d, pshf_q, pshf_d, pshb_q, pshb_d;
	logic [31:0]          popf_q, popf_d, popb_q, popb_d;
	logic                 head_match;
	logic                 in_acc;
	logic                 full;

	logic                 res_load;
	logic [1:0]           res_status;
	logic [ENTRY_W-1:0]   res_entry;

	logic                 m_tvalid_q;
	logic [1:0]           status_q;
	logic [ENTRY_W-1:0]   entry_out_q;
	logic [CNT_W-1:0]     fill_q;
	logic [31:0]          ovf_out_q, pshf_out_q, pshb_out_q, popf_out_q, popb_out_q;
	logic [63:0]          out_pay_wide;
	logic [31:0]          fill_wide;

	logic                 scanning;
	logic                 push_back_acc;
	logic [CNT_W-1:0]     cnt_inc;

	assign s_tready  = (state_q == dqt_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign in_acc    = s_tvalid && s_tready;
	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign pay_wide  = 64'(s_tdata[39:8]);
	assign new_entry = {s_tdata[7:0], pay_wide[PAYLOAD_BITS-1:0]};
	assign head      = cell_data[0];
	assign rd_idx    = IDX_W'(cnt_q - CNT_W'(1));
	assign head_match = !found_q && (head[ENTRY_W-1 -: dqt_pkg::TYPE_W] == stype_q);

	// row of cells, position 0 is the front
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ENTRY_W-1:0] lower_i;
		logic [ENTRY_W-1:0] upper_i;
		if (i == 0) begin : g_first
			assign lower_i = ins;
		end else begin : g_mid_lo
			assign lower_i = cell_data[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign upper_i = ins;
		end else begin : g_mid_hi
			assign upper_i = cell_data[i+1];
		end
		dqt_cell #(
			.ENTRY_W (ENTRY_W),
			.IDX_W   (IDX_W),
			.IDX     (i)
		) u_cell (
			.clk    (clk),
			.shift  (shift),
			.ld_idx (ld_idx),
			.rd_idx (rd_idx),
			.lower  (lower_i),
			.upper  (upper_i),
			.ins    (ins),
			.data   (cell_data[i]),
			.rd     (cell_rd[i])
		);
	end

	always_comb begin
		back_rd = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			back_rd = back_rd | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		shift      = '{mode: dqt_pkg::SH_HOLD, ld: 1'b0};
		ld_idx     = cnt_q[IDX_W-1:0];
		ins        = new_entry;
		cnt_d      = cnt_q;
		steps_d    = steps_q;
		found_d    = found_q;
		fnd_d      = fnd_q;
		stype_d    = stype_q;
		ovf_d      = ovf_q;
		pshf_d     = pshf_q;
		pshb_d     = pshb_q;
		popf_d     = popf_q;
		popb_d     = popb_q;
		res_load   = 1'b0;
		res_status = dqt_pkg::STATUS_OK;
		res_entry  = '0;
		unique case (state_q)
			dqt_pkg::ST_IDLE: begin
				if (in_acc) begin
					res_load = 1'b1;
					unique case (s_tuser)
						dqt_pkg::KIND_PUSH_BACK: begin
							if (full) begin
								ovf_d      = ovf_q + 32'd1;
								res_status = dqt_pkg::STATUS_FULL;
							end else begin
								shift.ld = 1'b1;
								cnt_d    = cnt_q + CNT_W'(1);
								pshb_d   = pshb_q + 32'd1;
							end
						end
						dqt_pkg::KIND_PUSH_FRONT: begin
							if (full) begin
								ovf_d      = ovf_q + 32'd1;
								res_status = dqt_pkg::STATUS_FULL;
							end else begin
								shift.mode = dqt_pkg::SH_UP;
								cnt_d      = cnt_q + CNT_W'(1);
								pshf_d     = pshf_q + 32'd1;
							end
						end
						dqt_pkg::KIND_POP_FRONT: begin
							if (cnt_q == '0) begin
								res_status = dqt_pkg::STATUS_EMPTY;
							end else begin
								res_entry  = head;
								shift.mode = dqt_pkg::SH_DOWN;
								cnt_d      = cnt_q - CNT_W'(1);
								popf_d     = popf_q + 32'd1;
							end
						end
						dqt_pkg::KIND_POP_BACK: begin
							if (cnt_q == '0) begin
								res_status = dqt_pkg::STATUS_EMPTY;
							end else begin
								res_entry = back_rd;
								cnt_d     = cnt_q - CNT_W'(1);
								popb_d    = popb_q + 32'd1;
							end
						end
						dqt_pkg::KIND_TAKE: begin
							if (cnt_q == '0) begin
								res_status = dqt_pkg::STATUS_EMPTY;
							end else begin
								res_load = 1'b0;
								state_d  = dqt_pkg::ST_SCAN;
								steps_d  = cnt_q;
								found_d  = 1'b0;
								stype_d  = s_tdata[7:0];
							end
						end
						default: ;
					endcase
				end
			end
			dqt_pkg::ST_SCAN: begin
				// head leaves; kept entries go back in at the tail
				ins        = head;
				shift.mode = dqt_pkg::SH_DOWN;
				ld_idx     = IDX_W'(cnt_q - CNT_W'(1));
				if (head_match) begin
					found_d = 1'b1;
					fnd_d   = head;
					cnt_d   = cnt_q - CNT_W'(1);
				end else begin
					shift.ld = 1'b1;
				end
				steps_d = steps_q - CNT_W'(1);
				if (steps_q == CNT_W'(1)) begin
					state_d  = dqt_pkg::ST_IDLE;
					res_load = 1'b1;
					if (found_d) begin
						res_entry = fnd_d;
						popf_d    = popf_q + 32'd1;
					end else begin
						res_status = dqt_pkg::STATUS_EMPTY;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			steps_q    <= '0;
			found_q    <= 1'b0;
			ovf_q      <= '0;
			pshf_q     <= '0;
			pshb_q     <= '0;
			popf_q     <= '0;
			popb_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			steps_q <= steps_d;
			found_q <= found_d;
			ovf_q   <= ovf_d;
			pshf_q  <= pshf_d;
			pshb_q  <= pshb_d;
			popf_q  <= popf_d;
			popb_q  <= popb_d;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fnd_q   <= fnd_d;
		stype_q <= stype_d;
		if (res_load) begin
			status_q    <= res_status;
			entry_out_q <= res_entry;
			fill_q      <= cnt_d;
			ovf_out_q   <= ovf_d;
			pshf_out_q  <= pshf_d;
			pshb_out_q  <= pshb_d;
			popf_out_q  <= popf_d;
			popb_out_q  <= popb_d;
		end
	end

	assign out_pay_wide = 64'(entry_out_q[PAYLOAD_BITS-1:0]);
	assign fill_wide    = 32'(fill_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, popb_out_q, popf_out_q, pshb_out_q, pshf_out_q, ovf_out_q,
		fill_wide[4:0], out_pay_wide[31:0], entry_out_q[ENTRY_W-1 -: dqt_pkg::TYPE_W]};

	assign scanning      = (state_q == dqt_pkg::ST_SCAN);
	assign push_back_acc = in_acc && (s_tuser == dqt_pkg::KIND_PUSH_BACK) && !full;
	assign cnt_inc       = cnt_q + CNT_W'(1);

	`DQT_ASSERT_ALWAYS(a_fill_bound, cnt_q <= CNT_W'(QUEUE_DEPTH), "fill above depth")
	`DQT_ASSERT_ALWAYS(a_scan_no_result, !scanning || !m_tvalid_q, "result during scan")
	`DQT_ASSERT_ALWAYS(a_fill_matches, !m_tvalid_q || (fill_q == cnt_q), "held fill differs")
	`DQT_ASSERT_NEXT(a_push_grows, push_back_acc, cnt_q == $past(cnt_inc), "push back kept fill")

endmodule

@@ sv/dqt_cell.sv @@
// ---------------------------------------------------------------------------
// dqt_cell
// one queue position: holds an entry, shifts to or from its neighbours,
// loads the broadcast entry when addressed, drives its entry when read
// ---------------------------------------------------------------------------
module dqt_cell #(
	parameter int ENTRY_W = 40,
	parameter int IDX_W   = 4,
	parameter int IDX     = 0
) (
	input  logic                clk,
	input  dqt_pkg::shift_ctrl_t shift,
	input  logic [IDX_W-1:0]    ld_idx,
	input  logic [IDX_W-1:0]    rd_idx,
	input  logic [ENTRY_W-1:0]  lower,
	input  logic [ENTRY_W-1:0]  upper,
	input  logic [ENTRY_W-1:0]  ins,
	output logic [ENTRY_W-1:0]  data,
	output logic [ENTRY_W-1:0]  rd
);

	logic [ENTRY_W-1:0] entry_q;
	logic [ENTRY_W-1:0] entry_d;
	logic               hit_ld;

	assign hit_ld = shift.ld && (ld_idx == IDX_W'(IDX));

	always_comb begin
		entry_d = entry_q;
		if (hit_ld) begin
			entry_d = ins;
		end else begin
			unique case (shift.mode)
				dqt_pkg::SH_UP:   entry_d = lower;
				dqt_pkg::SH_DOWN: entry_d = upper;
				default:          entry_d = entry_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign data = entry_q;
	assign rd   = (rd_idx == IDX_W'(IDX)) ? entry_q : '0;

endmodule

@@ tb/deque_checker.sv @@
// ---------------------------------------------------------------------------
// deque_checker
// watches both stream channels of the deque, keeps its own copy of the held
// messages and the five totals, and checks every result field by field
// ---------------------------------------------------------------------------
module deque_checker #(
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [39:0]  s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [207:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           fail_count,
	output int           outstanding,
	output int           results_seen,
	output int           full_hits,
	output int           empty_hits,
	output int           take_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  msg_type;
		logic [31:0] payload;
	} msg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_type;
		logic [31:0] out_payload;
		logic [4:0]  fill;
		logic [31:0] overflow_total;
		logic [31:0] push_front_total;
		logic [31:0] push_back_total;
		logic [31:0] pop_front_total;
		logic [31:0] pop_back_total;
	} outcome_t;

	// front of the deque is index 0
	msg_t        held_msgs[$];
	outcome_t    pending_outcomes[$];
	logic [31:0] n_overflow, n_push_front, n_push_back, n_pop_front, n_pop_back;

	function automatic outcome_t next_outcome(logic [2:0] kind, logic [7:0] mtype,
			logic [31:0] body);
		outcome_t o;
		msg_t     m;
		int       hit;
		o = '0;
		o.status = dqt_pkg::STATUS_OK;
		hit = -1;
		unique case (kind)
		dqt_pkg::KIND_PUSH_BACK, dqt_pkg::KIND_PUSH_FRONT: begin
			if (held_msgs.size() >= DEPTH) begin
				n_overflow++;
				o.status = dqt_pkg::STATUS_FULL;
			end else if (kind == dqt_pkg::KIND_PUSH_BACK) begin
				held_msgs.push_back(msg_t'({mtype, body}));
				n_push_back++;
			end else begin
				held_msgs.push_front(msg_t'({mtype, body}));
				n_push_front++;
			end
		end
		dqt_pkg::KIND_POP_FRONT, dqt_pkg::KIND_POP_BACK: begin
			if (held_msgs.size() == 0) begin
				o.status = dqt_pkg::STATUS_EMPTY;
			end else begin
				if (kind == dqt_pkg::KIND_POP_FRONT) begin
					m = held_msgs.pop_front();
					n_pop_front++;
				end else begin
					m = held_msgs.pop_back();
					n_pop_back++;
				end
				o.out_type = m.msg_type;
				o.out_payload = m.payload;
			end
		end
		dqt_pkg::KIND_TAKE: begin
			// first match seen from the front; the rest keep their order
			foreach (held_msgs[i])
				if (hit < 0 && held_msgs[i].msg_type == mtype)
					hit = i;
			if (hit < 0) begin
				o.status = dqt_pkg::STATUS_EMPTY;
			end else begin
				o.out_type = held_msgs[hit].msg_type;
				o.out_payload = held_msgs[hit].payload;
				held_msgs.delete(hit);
				n_pop_front++;
			end
		end
		default: ;
		endcase
		o.fill = 5'(held_msgs.size());
		o.overflow_total = n_overflow;
		o.push_front_total = n_push_front;
		o.push_back_total = n_push_back;
		o.pop_front_total = n_pop_front;
		o.pop_back_total = n_pop_back;
		return o;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			held_msgs.delete();
			pending_outcomes.delete();
			n_overflow = '0;
			n_push_front = '0;
			n_push_back = '0;
			n_pop_front = '0;
			n_pop_back = '0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_outcomes.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with nothing expected, status %0h tdata %0h",
						$time, m_tuser, m_tdata);
				end else begin
					want = pending_outcomes.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("out_type", want.out_type, m_tdata[7:0]);
					check_field("out_payload", want.out_payload, m_tdata[39:8]);
					check_field("fill_count", want.fill, m_tdata[44:40]);
					check_field("overflow_total", want.overflow_total, m_tdata[76:45]);
					check_field("push_front_total", want.push_front_total, m_tdata[108:77]);
					check_field("push_back_total", want.push_back_total, m_tdata[140:109]);
					check_field("pop_front_total", want.pop_front_total, m_tdata[172:141]);
					check_field("pop_back_total", want.pop_back_total, m_tdata[204:173]);
				end
			end
			if (s_tvalid && s_tready) begin
				want = next_outcome(s_tuser, s_tdata[7:0], s_tdata[39:8]);
				pending_outcomes.push_back(want);
				if (want.status == dqt_pkg::STATUS_FULL)
					full_hits++;
				if (want.status == dqt_pkg::STATUS_EMPTY)
					empty_hits++;
				if (s_tuser == dqt_pkg::KIND_TAKE && want.status == dqt_pkg::STATUS_OK)
					take_hits++;
			end
			outstanding = pending_outcomes.size();
		end
	end

endmodule

@@ tb/tb_deque_with_typed_extract.sv @@
// ---------------------------------------------------------------------------
// tb_deque_with_typed_extract
// drives push, pop and take-by-type items into the deque with random gaps
// and stalls; a side checker predicts and compares every result
// ---------------------------------------------------------------------------
module tb_deque_with_typed_extract;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int MIX_ITEMS = 50;
	localparam int MIX_ROUNDS = 13;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 2 * DEPTH;
	localparam logic [2:0] KIND_LAST_SPARE = 3'd7;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN,
		MIX_TAKE
	} mix_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [207:0] m_tdata;
	logic [1:0]   m_tuser;

	int   fail_count, outstanding, results_seen, full_hits, empty_hits, take_hits;
	int   items_sent;
	bit   sender_calm;
	logic [7:0] type_pool[4];

	always #1 clk = ~clk;

	deque_with_typed_extract #(
		.QUEUE_DEPTH (DEPTH),
		.PAYLOAD_BITS(32)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	deque_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.results_seen(results_seen),
		.full_hits   (full_hits),
		.empty_hits  (empty_hits),
		.take_hits   (take_hits)
	);

	// mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [2:0] pick_kind(mix_t mix);
		int r;
		int cut[4];
		r = $urandom_range(0, 99);
		if (r < 3)
			return dqt_pkg::KIND_TAKE + 3'($urandom_range(1, 3));
		unique case (mix)
		MIX_FILL:  cut = '{35, 70, 80, 88};
		MIX_DRAIN: cut = '{10, 20, 55, 85};
		MIX_EVEN:  cut = '{22, 44, 60, 76};
		default:   cut = '{20, 40, 48, 56};
		endcase
		r = $urandom_range(0, 99);
		if (r < cut[0])
			return dqt_pkg::KIND_PUSH_BACK;
		if (r < cut[1])
			return dqt_pkg::KIND_PUSH_FRONT;
		if (r < cut[2])
			return dqt_pkg::KIND_POP_FRONT;
		if (r < cut[3])
			return dqt_pkg::KIND_POP_BACK;
		return dqt_pkg::KIND_TAKE;
	endfunction

	// a small pool of types per round so that takes mostly find a match
	function automatic logic [7:0] pick_type();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return type_pool[$urandom_range(0, 3)];
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(logic [2:0] kind, logic [7:0] mtype, logic [31:0] body);
		int gap;
		gap = (sender_calm || $urandom_range(0, 3) != 0) ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {body, mtype};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin : sink
		int  stretch;
		int  stall;
		bit  calm;
		stall = 0;
		@(posedge arst_n);
		forever begin
			stretch = $urandom_range(50, 300);
			calm = ($urandom_range(0, 3) == 0);
			repeat (stretch) begin
				@(negedge clk);
				if (stall > 0) begin
					m_tready <= 1'b0;
					stall--;
				end else begin
					m_tready <= 1'b1;
					if (!calm && $urandom_range(0, 3) == 0)
						stall = gap_len();
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("tb_deque_with_typed_extract: errors");
		$finish;
	end

	initial begin : stimulus
		int   i;
		int   round;
		mix_t mix;
		sender_calm = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// removals on an empty deque, and a spare code
		send_item(dqt_pkg::KIND_POP_FRONT, 8'h00, 32'h0000_0000);
		send_item(dqt_pkg::KIND_POP_BACK, 8'hff, 32'hffff_ffff);
		send_item(dqt_pkg::KIND_TAKE, 8'h00, 32'h0000_0000);
		send_item(KIND_LAST_SPARE, 8'hff, 32'hffff_ffff);

		// fill from both ends, with repeated types, then push into a full deque
		for (i = 0; i < DEPTH; i++)
			send_item(i[0] ? dqt_pkg::KIND_PUSH_FRONT : dqt_pkg::KIND_PUSH_BACK,
				(i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'h10 + 8'(i % 3),
				(i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : $urandom());
		send_item(dqt_pkg::KIND_PUSH_BACK, 8'h5a, 32'ha5a5_a5a5);
		send_item(dqt_pkg::KIND_PUSH_FRONT, 8'ha5, 32'h5a5a_5a5a);

		// take that finds nothing, take among repeated types, then a back pop
		send_item(dqt_pkg::KIND_TAKE, 8'h77, 32'h0);
		send_item(dqt_pkg::KIND_TAKE, 8'h11, 32'h0);
		send_item(dqt_pkg::KIND_POP_BACK, 8'h00, 32'h0);
		s_tvalid <= 1'b0;
		wait_drained();

		for (round = 0; round < MIX_ROUNDS; round++) begin
			mix = (round < 4) ? mix_t'(round) : mix_t'($urandom_range(0, 3));
			sender_calm = ($urandom_range(0, 3) == 0);
			foreach (type_pool[k])
				type_pool[k] = 8'($urandom_range(0, 255));
			// hold off once until every result is back
			if (round == 6) begin
				s_tvalid <= 1'b0;
				wait_drained();
			end
			repeat (MIX_ITEMS)
				send_item(pick_kind(mix), pick_type(), $urandom());
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run covered %0d items and %0d checked results", items_sent, results_seen);
		$display("  %0d pushes refused when full, %0d empty or unmatched removals, %0d takes",
			full_hits, empty_hits, take_hits);
		if (fail_count == 0)
			$display("tb_deque_with_typed_extract: clean");
		else
			$display("tb_deque_with_typed_extract: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dqt_pkg.sv
sv/dqt_cell.sv
sv/deque_with_typed_extract.sv
tb/deque_checker.sv
tb/tb_deque_with_typed_extract.sv
